>>> hdl/rfwds_pkg.sv
// Shared types and constants for the read-first write-deadline scheduler.
// No dependencies; imported by every module of the block.
package rfwds_pkg;

  localparam int READ_DEPTH_DEF      = 32;
  localparam int WRITE_DEPTH_DEF     = 32;
  localparam int MAX_BUNDLE_SCAN_DEF = 5;

  localparam int SECTOR_W = 48;
  localparam int TAG_W    = 8;
  localparam int TIME_W   = 32;

  localparam logic [15:0] EXPIRY_RST     = 16'd125;
  localparam logic [4:0]  REGION_RST     = 5'd13;
  localparam logic        BUNDLE_EN_RST  = 1'b1;
  localparam logic [2:0]  BUNDLE_LIM_RST = 3'd5;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_EXPIRY     = 2'd0,
    CFG_REGION     = 2'd1,
    CFG_BUNDLE_EN  = 2'd2,
    CFG_BUNDLE_LIM = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DISPATCH,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_EMIT_HEAD,
    S_EMIT_BUF,
    S_WB
  } back_state_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                is_write;
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
  } in_beat_t;

  typedef struct packed {
    kind_t               kind;
    logic [TAG_W-1:0]    out_tag;
    logic [SECTOR_W-1:0] out_sector;
    logic                last;
  } out_beat_t;

  typedef struct packed {
    op_t                 op;
    logic                is_write;
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
  } op_beat_t;

  typedef struct packed {
    logic [15:0] expiry;
    logic [4:0]  region;
    logic        bundle_en;
    logic [2:0]  bundle_lim;
  } cfg_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
  } rq_entry_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
    logic [TIME_W-1:0]   deadline;
  } wq_entry_t;

endpackage

>>> hdl/rfwds_front.sv
// Front end: accepts input beats, decodes the command, drops unused ones and queues ops.
// Depends on rfwds_pkg.
module rfwds_front import rfwds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     op_valid,
  input  logic     op_ready,
  output op_beat_t op_data
);

  op_beat_t   q_mem [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop, keep;
  op_beat_t   cls;

  assign in_ready = (cnt_r != 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op_data  = q_mem[rp_r];

  always_comb begin
    cls.is_write = in_data.is_write;
    cls.sector   = in_data.sector;
    cls.tag      = in_data.tag;
    keep         = 1'b1;
    case (cmd_t'(in_data.cmd))
      CMD_ADD:      cls.op = OP_ADD;
      CMD_DISPATCH: cls.op = OP_DISPATCH;
      CMD_TICK:     cls.op = OP_TICK;
      default: begin
        cls.op = OP_TICK;
        keep   = 1'b0;
      end
    endcase
  end

  assign push = in_valid && in_ready && keep;
  assign pop  = op_valid && op_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= cls;
    end
  end

endmodule

>>> hdl/rfwds_back.sv
// Back end: read FIFO, write queue with deadlines, dispatch and bundling.
// Depends on rfwds_pkg.
module rfwds_back import rfwds_pkg::*; #(
  parameter int READ_DEPTH      = READ_DEPTH_DEF,
  parameter int WRITE_DEPTH     = WRITE_DEPTH_DEF,
  parameter int MAX_BUNDLE_SCAN = MAX_BUNDLE_SCAN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      op_valid,
  output logic      op_ready,
  input  op_beat_t  op_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int RPW = $clog2(READ_DEPTH);
  localparam int RCW = $clog2(READ_DEPTH + 1);
  localparam int WPW = $clog2(WRITE_DEPTH);
  localparam int WCW = $clog2(WRITE_DEPTH + 1);
  localparam int NW  = $clog2(MAX_BUNDLE_SCAN + 1);
  localparam int IW  = (MAX_BUNDLE_SCAN > 1) ? $clog2(MAX_BUNDLE_SCAN) : 1;

  rq_entry_t rq_mem [READ_DEPTH];
  wq_entry_t wq_mem [WRITE_DEPTH];
  wq_entry_t bnd_mem [MAX_BUNDLE_SCAN];

  back_state_t state_r, state_nxt;

  logic [RPW-1:0]    rhead_r, rhead_nxt, rtail_r, rtail_nxt;
  logic [RCW-1:0]    rcnt_r, rcnt_nxt;
  logic [WPW-1:0]    whead_r, whead_nxt, wtail_r, wtail_nxt;
  logic [WCW-1:0]    wcnt_r, wcnt_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [WPW-1:0]    sp_r, sp_nxt, nh_r, nh_nxt, wb_r, wb_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [NW-1:0]     n_r, n_nxt, mcnt_r, mcnt_nxt, n_calc;
  logic [MAX_BUNDLE_SCAN-1:0] match_r, match_nxt;
  wq_entry_t         hd_r, hd_nxt;

  rq_entry_t      rq_rd_r, rq_wdata;
  wq_entry_t      wq_rd_r, wq_wdata;
  logic           rq_we, wq_we, bnd_we;
  logic [WPW-1:0] wq_waddr, wq_raddr;

  logic      out_valid_r;
  out_beat_t out_r;
  logic      emit;
  out_beat_t emit_beat;

  logic              can_emit, take_write, expired, same_region, later_any, i_last;
  logic [TIME_W-1:0] age;

  function automatic logic [WPW-1:0] winc(input logic [WPW-1:0] p);
    return (p == WPW'(WRITE_DEPTH - 1)) ? '0 : p + WPW'(1);
  endfunction

  function automatic logic [RPW-1:0] rinc(input logic [RPW-1:0] p);
    return (p == RPW'(READ_DEPTH - 1)) ? '0 : p + RPW'(1);
  endfunction

  assign can_emit    = !out_valid_r || out_ready;
  assign age         = time_r - wq_rd_r.deadline;
  assign expired     = !age[TIME_W-1];
  assign take_write  = (wcnt_r != '0) && (expired || (rcnt_r == '0));
  assign same_region = ((wq_rd_r.sector >> cfg.region) == (hd_r.sector >> cfg.region));
  assign i_last      = ((NW'(i_r) + NW'(1)) == n_r);
  assign wq_raddr    = (state_r == S_SCAN_RD) ? sp_r : whead_r;

  always_comb begin
    int lim_i, avail_i;
    lim_i = cfg.bundle_en ? int'(cfg.bundle_lim) : 0;
    if (lim_i > MAX_BUNDLE_SCAN) lim_i = MAX_BUNDLE_SCAN;
    avail_i = int'(wcnt_r) - 1;
    if (avail_i < lim_i) lim_i = avail_i;
    if (lim_i < 0) lim_i = 0;
    n_calc = NW'(lim_i);
  end

  always_comb begin
    later_any = 1'b0;
    for (int j = 0; j < MAX_BUNDLE_SCAN; j++) begin
      if (match_r[j] && (j > int'(i_r))) later_any = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (op_valid && can_emit && (op_data.op == OP_DISPATCH)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (take_write) state_nxt = (n_calc == '0) ? S_EMIT_HEAD : S_SCAN_RD;
        else if (can_emit) state_nxt = S_IDLE;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CK;
      S_SCAN_CK: state_nxt = i_last ? S_EMIT_HEAD : S_SCAN_RD;
      S_EMIT_HEAD: begin
        if (can_emit) begin
          if (n_r == '0) state_nxt = S_IDLE;
          else if (match_r == '0) state_nxt = S_WB;
          else state_nxt = S_EMIT_BUF;
        end
      end
      S_EMIT_BUF: begin
        if ((!match_r[i_r] || can_emit) && i_last) state_nxt = S_WB;
      end
      S_WB: begin
        if (i_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rhead_nxt = rhead_r;
    rtail_nxt = rtail_r;
    rcnt_nxt  = rcnt_r;
    whead_nxt = whead_r;
    wtail_nxt = wtail_r;
    wcnt_nxt  = wcnt_r;
    time_nxt  = time_r;
    sp_nxt    = sp_r;
    nh_nxt    = nh_r;
    wb_nxt    = wb_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    mcnt_nxt  = mcnt_r;
    match_nxt = match_r;
    hd_nxt    = hd_r;
    rq_we     = 1'b0;
    wq_we     = 1'b0;
    bnd_we    = 1'b0;
    rq_wdata  = '{sector: op_data.sector, tag: op_data.tag};
    wq_wdata  = '{sector: op_data.sector, tag: op_data.tag,
                  deadline: time_r + TIME_W'(cfg.expiry)};
    wq_waddr  = wtail_r;
    op_ready  = 1'b0;
    emit      = 1'b0;
    emit_beat = '{kind: KIND_EMPTY, out_tag: '0, out_sector: '0, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (op_valid && can_emit) begin
          op_ready = 1'b1;
          case (op_data.op)
            OP_ADD: begin
              if (op_data.is_write) begin
                if (wcnt_r == WCW'(WRITE_DEPTH)) begin
                  emit      = 1'b1;
                  emit_beat = '{kind: KIND_FULL, out_tag: op_data.tag,
                                out_sector: op_data.sector, last: 1'b1};
                end else begin
                  wq_we     = 1'b1;
                  wtail_nxt = winc(wtail_r);
                  wcnt_nxt  = wcnt_r + WCW'(1);
                end
              end else begin
                if (rcnt_r == RCW'(READ_DEPTH)) begin
                  emit      = 1'b1;
                  emit_beat = '{kind: KIND_FULL, out_tag: op_data.tag,
                                out_sector: op_data.sector, last: 1'b1};
                end else begin
                  rq_we     = 1'b1;
                  rtail_nxt = rinc(rtail_r);
                  rcnt_nxt  = rcnt_r + RCW'(1);
                end
              end
            end
            OP_TICK: time_nxt = time_r + TIME_W'(1);
            default: ;
          endcase
        end
      end
      S_DECIDE: begin
        if (take_write) begin
          hd_nxt    = wq_rd_r;
          n_nxt     = n_calc;
          i_nxt     = '0;
          sp_nxt    = winc(whead_r);
          nh_nxt    = winc(whead_r);
          mcnt_nxt  = '0;
          match_nxt = '0;
        end else if (can_emit) begin
          emit = 1'b1;
          if (rcnt_r != '0) begin
            emit_beat = '{kind: KIND_READ, out_tag: rq_rd_r.tag,
                          out_sector: rq_rd_r.sector, last: 1'b1};
            rhead_nxt = rinc(rhead_r);
            rcnt_nxt  = rcnt_r - RCW'(1);
          end
        end
      end
      S_SCAN_CK: begin
        bnd_we           = 1'b1;
        match_nxt[i_r]   = same_region;
        sp_nxt           = winc(sp_r);
        if (same_region) begin
          nh_nxt   = winc(nh_r);
          mcnt_nxt = mcnt_r + NW'(1);
        end
        i_nxt = i_last ? '0 : i_r + IW'(1);
      end
      S_EMIT_HEAD: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_beat = '{kind: KIND_WRITE, out_tag: hd_r.tag,
                        out_sector: hd_r.sector, last: (match_r == '0)};
          whead_nxt = nh_r;
          wcnt_nxt  = wcnt_r - WCW'(1) - WCW'(mcnt_r);
          wb_nxt    = nh_r;
          i_nxt     = '0;
        end
      end
      S_EMIT_BUF: begin
        if (!match_r[i_r] || can_emit) begin
          if (match_r[i_r]) begin
            emit      = 1'b1;
            emit_beat = '{kind: KIND_WRITE, out_tag: bnd_mem[i_r].tag,
                          out_sector: bnd_mem[i_r].sector, last: !later_any};
          end
          i_nxt = i_last ? '0 : i_r + IW'(1);
        end
      end
      S_WB: begin
        if (!match_r[i_r]) begin
          wq_we    = 1'b1;
          wq_waddr = wb_r;
          wq_wdata = bnd_mem[i_r];
          wb_nxt   = winc(wb_r);
        end
        i_nxt = i_r + IW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rhead_r     <= '0;
      rtail_r     <= '0;
      rcnt_r      <= '0;
      whead_r     <= '0;
      wtail_r     <= '0;
      wcnt_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rhead_r   <= rhead_nxt;
      rtail_r   <= rtail_nxt;
      rcnt_r    <= rcnt_nxt;
      whead_r   <= whead_nxt;
      wtail_r   <= wtail_nxt;
      wcnt_r    <= wcnt_nxt;
      time_r    <= time_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sp_r    <= sp_nxt;
    nh_r    <= nh_nxt;
    wb_r    <= wb_nxt;
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    mcnt_r  <= mcnt_nxt;
    match_r <= match_nxt;
    hd_r    <= hd_nxt;
    if (emit) out_r <= emit_beat;
  end

  always_ff @(posedge clk) begin
    if (rq_we) rq_mem[rtail_r] <= rq_wdata;
    rq_rd_r <= rq_mem[rhead_r];
  end

  always_ff @(posedge clk) begin
    if (wq_we) wq_mem[wq_waddr] <= wq_wdata;
    wq_rd_r <= wq_mem[wq_raddr];
  end

  always_ff @(posedge clk) begin
    if (bnd_we) bnd_mem[i_r] <= wq_rd_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= WCW'(WRITE_DEPTH)) else $error("write count above depth");
  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= RCW'(READ_DEPTH)) else $error("read count above depth");
  a_scan_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN_CK |-> $past(state_r) == S_SCAN_RD) else $error("scan out of order");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    op_ready |-> state_r == S_IDLE) else $error("op taken while busy");

endmodule

>>> hdl/read_first_write_deadline_scheduler_unit.sv
// Top level: configuration registers, front end and back end.
// Depends on rfwds_pkg, rfwds_front and rfwds_back.
// Add and tick finish in the back end's idle state; accepted items first pass the front
// end's two-entry queue. Read dispatch or empty is settled in the decide state; write
// dispatch scans n writes (0..MAX_BUNDLE_SCAN), emits the head, then bundled writes,
// and writes the rest back. Results appear in the output register the cycle after issue.
// Synchronous active-low reset empties both queues, clears time, loads register defaults.
module read_first_write_deadline_scheduler_unit import rfwds_pkg::*; #(
  parameter int READ_DEPTH      = READ_DEPTH_DEF,
  parameter int WRITE_DEPTH     = WRITE_DEPTH_DEF,
  parameter int MAX_BUNDLE_SCAN = MAX_BUNDLE_SCAN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     op_valid, op_ready;
  op_beat_t op_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_EXPIRY:     cfg_nxt.expiry     = cfg_data;
        CFG_REGION:     cfg_nxt.region     = cfg_data[4:0];
        CFG_BUNDLE_EN:  cfg_nxt.bundle_en  = cfg_data[0];
        CFG_BUNDLE_LIM: cfg_nxt.bundle_lim = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{expiry: EXPIRY_RST, region: REGION_RST,
                 bundle_en: BUNDLE_EN_RST, bundle_lim: BUNDLE_LIM_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rfwds_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op_data  (op_data)
  );

  rfwds_back #(
    .READ_DEPTH      (READ_DEPTH),
    .WRITE_DEPTH     (WRITE_DEPTH),
    .MAX_BUNDLE_SCAN (MAX_BUNDLE_SCAN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op_data   (op_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sim/tb_read_first_write_deadline_scheduler_unit.sv
// Testbench for the read-first write-deadline scheduler: random and directed beats,
// scoreboard predicts dispatch order and bundling. Depends on rfwds_pkg and the RTL.
module tb_read_first_write_deadline_scheduler_unit;
  import rfwds_pkg::*;

  typedef struct {
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
    logic [TIME_W-1:0]   deadline;
  } req_t;

  class sched_scoreboard;
    req_t rd_fifo[$];
    req_t wr_fifo[$];
    logic [TIME_W-1:0] now;
    logic [15:0] expiry;
    logic [4:0] region_log2;
    logic bundle_en;
    logic [2:0] bundle_lim;
    out_beat_t pending[$];
    int errors;

    function void clear();
      rd_fifo.delete(); wr_fifo.delete(); pending.delete();
      now = 0; expiry = EXPIRY_RST; region_log2 = REGION_RST;
      bundle_en = BUNDLE_EN_RST; bundle_lim = BUNDLE_LIM_RST; errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_EXPIRY:     expiry = v;
        CFG_REGION:     region_log2 = v[4:0];
        CFG_BUNDLE_EN:  bundle_en = v[0];
        CFG_BUNDLE_LIM: bundle_lim = v[2:0];
        default: ;
      endcase
    endfunction

    function void push(kind_t k, logic [TAG_W-1:0] t, logic [SECTOR_W-1:0] s, logic l);
      out_beat_t b;
      b.kind = k; b.out_tag = t; b.out_sector = s; b.last = l;
      pending.push_back(b);
    endfunction

    function void note_input(in_beat_t b);
      req_t e, h;
      req_t keep[$];
      int lim, scanned;
      logic [TIME_W-1:0] age;
      logic [SECTOR_W-1:0] reg_id;
      case (b.cmd)
        CMD_ADD: begin
          e.sector = b.sector; e.tag = b.tag; e.deadline = now + expiry;
          if (b.is_write) begin
            if (wr_fifo.size() >= WRITE_DEPTH_DEF) push(KIND_FULL, b.tag, b.sector, 1);
            else wr_fifo.push_back(e);
          end else begin
            if (rd_fifo.size() >= READ_DEPTH_DEF) push(KIND_FULL, b.tag, b.sector, 1);
            else rd_fifo.push_back(e);
          end
        end
        CMD_DISPATCH: begin
          if (wr_fifo.size() > 0) age = now - wr_fifo[0].deadline;
          if (wr_fifo.size() > 0 && (!age[31] || rd_fifo.size() == 0)) begin
            h = wr_fifo.pop_front();
            reg_id = h.sector >> region_log2;
            lim = bundle_en ? bundle_lim : 0;
            if (lim > MAX_BUNDLE_SCAN_DEF) lim = MAX_BUNDLE_SCAN_DEF;
            push(KIND_WRITE, h.tag, h.sector, 0);
            scanned = 0;
            foreach (wr_fifo[i]) begin
              if (scanned < lim) begin
                scanned++;
                if ((wr_fifo[i].sector >> region_log2) == reg_id) begin
                  push(KIND_WRITE, wr_fifo[i].tag, wr_fifo[i].sector, 0);
                  continue;
                end
              end
              keep.push_back(wr_fifo[i]);
            end
            wr_fifo = keep;
            pending[pending.size()-1].last = 1;
          end else if (rd_fifo.size() > 0) begin
            h = rd_fifo.pop_front();
            push(KIND_READ, h.tag, h.sector, 1);
          end else push(KIND_EMPTY, 0, 0, 1);
        end
        CMD_TICK: now = now + 1;
        default: ;
      endcase
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result actual %p", $time, got);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.kind !== x.kind || got.out_tag !== x.out_tag ||
          got.out_sector !== x.out_sector || got.last !== x.last) begin
        $display("%0t: mismatch expected %p actual %p", $time, x, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_beat_t in_data;
  out_beat_t out_data;
  cfg_idx_t cfg_index;
  logic [15:0] cfg_data;
  sched_scoreboard sb;
  int cycles;
  bit calm;

  read_first_write_deadline_scheduler_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: sample at rising edge, stall at falling edge
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        out_ready = 0;
        repeat (gap) @(negedge clk);
        out_ready = 1;
      end else out_ready = 1;
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic w, logic [SECTOR_W-1:0] s, logic [7:0] t);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 11)) @(negedge clk);
    in_valid = 1;
    in_data.cmd = cmd; in_data.is_write = w; in_data.sector = s; in_data.tag = t;
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid = 1; cfg_index = idx; cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [SECTOR_W-1:0] rand_sector(bit near);
    logic [SECTOR_W-1:0] s;
    s = 48'({$urandom, $urandom});
    if (near) s = {36'h0000_0_1234, 12'(s)} ^ (s[0] ? 48'h0 : 48'h2000);
    return s;
  endfunction

  task automatic random_phase(int n, int wr_bias);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 9);
      if (c < 5) send_beat(CMD_ADD, $urandom_range(0, 9) < wr_bias,
                           rand_sector($urandom_range(0, 3) != 0), 8'($urandom));
      else if (c < 8) send_beat(CMD_DISPATCH, 1'($urandom), rand_sector(1'b0), 8'($urandom));
      else if (c < 9) send_beat(CMD_TICK, 1'($urandom), rand_sector(1'b0), 8'($urandom));
      else send_beat(CMD_NONE, 1'($urandom), rand_sector(1'b0), 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycles = 0; calm = 0;
    rst_n = 0; in_valid = 0; out_ready = 1; cfg_valid = 0;
    in_data = '0; cfg_index = CFG_EXPIRY; cfg_data = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    // directed: empty, extremes, read priority, deadline, bundling, unused cmd, full queues
    send_beat(CMD_DISPATCH, 0, 0, 0);
    send_beat(CMD_ADD, 0, 48'hFFFF_FFFF_FFFF, 8'hFF);
    send_beat(CMD_ADD, 1, 48'h0, 8'h00);
    send_beat(CMD_ADD, 1, 48'h1FFF, 8'h11);
    send_beat(CMD_ADD, 1, 48'h2000, 8'h22);
    send_beat(CMD_ADD, 1, 48'h0100, 8'h33);
    send_beat(CMD_DISPATCH, 0, 0, 0);
    send_beat(CMD_DISPATCH, 0, 0, 0);
    send_beat(CMD_NONE, 1, 48'hAAAA_5555_AAAA, 8'h5A);
    send_beat(CMD_DISPATCH, 0, 0, 0);
    write_reg(CFG_EXPIRY, 16'd0);
    send_beat(CMD_ADD, 0, 48'h1234, 8'h44);
    send_beat(CMD_ADD, 1, 48'h5555_0000_0000, 8'h55);
    send_beat(CMD_DISPATCH, 0, 0, 0);
    send_beat(CMD_TICK, 0, 0, 0);
    send_beat(CMD_DISPATCH, 0, 0, 0);
    send_beat(CMD_DISPATCH, 0, 0, 0);
    for (int i = 0; i < 33; i++) send_beat(CMD_ADD, 1, 48'(i), 8'(i));
    for (int i = 0; i < 33; i++) send_beat(CMD_ADD, 0, 48'(i), 8'(i + 64));
    for (int i = 0; i < 14; i++) send_beat(CMD_DISPATCH, 0, 0, 0);

    write_reg(CFG_REGION, 16'd9);
    write_reg(CFG_BUNDLE_LIM, 16'd7);
    write_reg(CFG_EXPIRY, 16'hFFFF);
    random_phase(8, 5);
    write_reg(CFG_REGION, 16'd24);
    write_reg(CFG_BUNDLE_EN, 16'd0);
    write_reg(CFG_EXPIRY, 16'd3);
    random_phase(8, 6);
    write_reg(CFG_BUNDLE_EN, 16'd1);
    write_reg(CFG_BUNDLE_LIM, 16'd0);
    random_phase(6, 4);
    write_reg(CFG_BUNDLE_LIM, 16'd2);
    write_reg(CFG_REGION, 16'd13);
    calm = 1;
    random_phase(8, 5);

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
